/* design/otq_pkg.sv */
// ----------------------------------------------------------------------------
// otq_pkg : shared types and constants of the ordered timer queue
// Field widths, request and result codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package otq_pkg;

    localparam int TIME_W      = 48;
    localparam int INT_W       = 32;
    localparam int ID_W        = 16;
    localparam int MIN_W       = 20;
    localparam int ENTRY_W     = ID_W + INT_W + TIME_W;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS);

    localparam logic [MIN_W-1:0] MIN_DELAY_RESET = 20'd100;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_SCAN,
        ST_A_CALC,
        ST_A_OUT,
        ST_T_PICK,
        ST_T_FIRE,
        ST_T_MIN,
        ST_T_CALC,
        ST_T_OUT
    } state_t;

    typedef enum logic {
        SCAN_PICK,
        SCAN_MIN
    } scan_mode_t;

    typedef enum logic [2:0] {
        OUT_ADD,
        OUT_FULL,
        OUT_FIRE_MID,
        OUT_FIRE_LAST,
        OUT_TICK_NONE
    } out_kind_t;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       clear_pick;
        logic       add_write;
        logic       fire_update;
        logic       calc;
        logic       out_load;
        out_kind_t  out_kind;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic free_found;
        logic pend;
        logic fire_last;
        logic out_free;
    } status_t;

endpackage

/* design/ordered_timer_queue_unit.sv */
// ----------------------------------------------------------------------------
// ordered_timer_queue_unit : ordered software timer queue
// Keeps a table of timers; adds report a new earliest, ticks emit expired
// timers earliest first and re-arm the deadline to the earliest remaining.
// ----------------------------------------------------------------------------
//
//  channel   ports                 beats per item
//  -------   -------------------   -----------------------------------------
//  input     s_valid / s_ready     one request (add or tick)
//  result    m_valid / m_ready     add: one; tick: one per fired timer, one if none (1..16)
//  config    cfg_wr_en / data      one write of min_delay_us, no stall
//
//  Every step walks the slot RAM once, one slot a cycle through its single
//  read port. An add takes one pass. A tick takes fired + 2 passes (17 when
//  sixteen fire). Reset clears the valid bits at once, so no clearing pass
//  is needed. A stalled result beat holds the sequencer before the next beat.
module ordered_timer_queue_unit #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [otq_pkg::MIN_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [otq_pkg::TIME_W-1:0]  s_current_time,
    input  logic [otq_pkg::TIME_W-1:0]  s_expiry_time,
    input  logic [otq_pkg::INT_W-1:0]   s_repeat_interval,
    input  logic [otq_pkg::ID_W-1:0]    s_new_timer_id,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [otq_pkg::ID_W-1:0]    m_fired_timer_id,
    output logic                        m_fired,
    output logic                        m_earliest_changed,
    output logic                        m_rearm,
    output logic [otq_pkg::TIME_W-1:0]  m_rearm_delay,
    output logic                        m_table_full,
    output logic                        m_last
);

    otq_pkg::cmd_t    cmd;
    otq_pkg::status_t sts;

    // sequencer: decides each step from the datapath status
    otq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath: slot store, scan, delay and result beat
    otq_dp #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_req_type         (s_req_type),
        .s_current_time     (s_current_time),
        .s_expiry_time      (s_expiry_time),
        .s_repeat_interval  (s_repeat_interval),
        .s_new_timer_id     (s_new_timer_id),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_fired_timer_id   (m_fired_timer_id),
        .m_fired            (m_fired),
        .m_earliest_changed (m_earliest_changed),
        .m_rearm            (m_rearm),
        .m_rearm_delay      (m_rearm_delay),
        .m_table_full       (m_table_full),
        .m_last             (m_last)
    );

    // a refused add carries nothing else and closes its item
    a_full_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_table_full |-> m_last && !m_fired && !m_rearm)
        else $error("table_full beat carries other fields");

    // a re-arm only ever rides on the closing beat of an item
    a_rearm_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_rearm || m_earliest_changed) |-> m_last)
        else $error("re-arm on a non-final beat");

    // an accepted item keeps the input closed while it is worked on
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input reopened straight after accept");

endmodule

/* design/otq_ram.sv */
// ----------------------------------------------------------------------------
// otq_ram : generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module otq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/otq_ctrl.sv */
// ----------------------------------------------------------------------------
// otq_ctrl : sequencer of the ordered timer queue
// Steps an add or a tick through scan, update, delay and result beats.
// ----------------------------------------------------------------------------
module otq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_req_type,
    output logic             s_ready,
    input  otq_pkg::status_t sts,
    output otq_pkg::cmd_t    cmd
);

    otq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= otq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.scan_mode  = otq_pkg::SCAN_MIN;
        cmd.out_kind   = otq_pkg::OUT_ADD;
        s_ready        = 1'b0;
        unique case (state_reg)
            otq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    if (s_req_type == otq_pkg::REQ_TICK) begin
                        cmd.scan_mode  = otq_pkg::SCAN_PICK;
                        cmd.clear_pick = 1'b1;
                        state_next     = otq_pkg::ST_T_PICK;
                    end else begin
                        state_next = otq_pkg::ST_A_SCAN;
                    end
                end
            end
            otq_pkg::ST_A_SCAN: begin
                if (sts.scan_done) begin
                    if (sts.free_found) begin
                        cmd.add_write = 1'b1;
                        state_next    = otq_pkg::ST_A_CALC;
                    end else begin
                        state_next = otq_pkg::ST_A_OUT;
                    end
                end
            end
            otq_pkg::ST_A_CALC: begin
                cmd.calc   = 1'b1;
                state_next = otq_pkg::ST_A_OUT;
            end
            otq_pkg::ST_A_OUT: begin
                cmd.out_kind = sts.free_found ? otq_pkg::OUT_ADD : otq_pkg::OUT_FULL;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = otq_pkg::ST_IDLE;
                end
            end
            otq_pkg::ST_T_PICK: begin
                if (sts.scan_done) begin
                    if (sts.found) begin
                        state_next = otq_pkg::ST_T_FIRE;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = otq_pkg::ST_T_MIN;
                    end
                end
            end
            otq_pkg::ST_T_FIRE: begin
                // hold until an earlier fired beat can be passed on
                if (!sts.pend || sts.out_free) begin
                    cmd.out_load    = sts.pend;
                    cmd.out_kind    = otq_pkg::OUT_FIRE_MID;
                    cmd.fire_update = 1'b1;
                    cmd.scan_start  = 1'b1;
                    if (sts.fire_last) begin
                        state_next = otq_pkg::ST_T_MIN;
                    end else begin
                        cmd.scan_mode = otq_pkg::SCAN_PICK;
                        state_next    = otq_pkg::ST_T_PICK;
                    end
                end
            end
            otq_pkg::ST_T_MIN: begin
                if (sts.scan_done) begin
                    state_next = otq_pkg::ST_T_CALC;
                end
            end
            otq_pkg::ST_T_CALC: begin
                cmd.calc   = 1'b1;
                state_next = otq_pkg::ST_T_OUT;
            end
            otq_pkg::ST_T_OUT: begin
                cmd.out_kind = sts.pend ? otq_pkg::OUT_FIRE_LAST : otq_pkg::OUT_TICK_NONE;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = otq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = otq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/otq_dp.sv */
// ----------------------------------------------------------------------------
// otq_dp : datapath of the ordered timer queue
// Slot RAM, valid and picked bits, scan comparator, delay unit, result register.
// ----------------------------------------------------------------------------
module otq_dp #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  otq_pkg::cmd_t                cmd,
    output otq_pkg::status_t             sts,
    input  logic                         cfg_wr_en,
    input  logic [otq_pkg::MIN_W-1:0]    cfg_wr_data,
    input  logic                         s_req_type,
    input  logic [otq_pkg::TIME_W-1:0]   s_current_time,
    input  logic [otq_pkg::TIME_W-1:0]   s_expiry_time,
    input  logic [otq_pkg::INT_W-1:0]    s_repeat_interval,
    input  logic [otq_pkg::ID_W-1:0]     s_new_timer_id,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [otq_pkg::ID_W-1:0]     m_fired_timer_id,
    output logic                         m_fired,
    output logic                         m_earliest_changed,
    output logic                         m_rearm,
    output logic [otq_pkg::TIME_W-1:0]   m_rearm_delay,
    output logic                         m_table_full,
    output logic                         m_last
);

    localparam int IDX_W = $clog2(TIMER_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

    // request capture
    logic                        req_reg;
    logic [otq_pkg::TIME_W-1:0]  now_reg;
    logic [otq_pkg::TIME_W-1:0]  exp_in_reg;
    logic [otq_pkg::INT_W-1:0]   int_in_reg;
    logic [otq_pkg::ID_W-1:0]    id_in_reg;
    logic [otq_pkg::MIN_W-1:0]   min_delay_reg;

    // slot flags
    logic [TIMER_SLOTS-1:0] valid_reg;
    logic [TIMER_SLOTS-1:0] picked_reg;

    // scan
    logic                        run_reg;
    logic [IDX_W-1:0]            cnt_reg;
    logic                        rd_vld_reg;
    logic [IDX_W-1:0]            rd_idx_reg;
    logic                        done_reg;
    otq_pkg::scan_mode_t         mode_reg;
    logic                        found_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [otq_pkg::TIME_W-1:0]  best_exp_reg;
    logic [otq_pkg::INT_W-1:0]   best_int_reg;
    logic [otq_pkg::ID_W-1:0]    best_id_reg;
    logic                        free_found_reg;
    logic [IDX_W-1:0]            free_idx_reg;

    // tick bookkeeping and delay
    logic                           pend_reg;
    logic [otq_pkg::ID_W-1:0]       pend_id_reg;
    logic [otq_pkg::FIRE_CNT_W-1:0] fire_cnt_reg;
    logic                           changed_reg;
    logic                           rearm_reg;
    logic [otq_pkg::TIME_W-1:0]     delay_reg;

    // result register
    logic                        m_valid_reg;
    logic [otq_pkg::ID_W-1:0]    m_id_reg;
    logic                        m_fired_reg;
    logic                        m_changed_reg;
    logic                        m_rearm_reg;
    logic [otq_pkg::TIME_W-1:0]  m_delay_reg;
    logic                        m_full_reg;
    logic                        m_last_reg;
    logic [otq_pkg::ID_W-1:0]    m_id_next;
    logic                        m_fired_next;
    logic                        m_changed_next;
    logic                        m_rearm_next;
    logic [otq_pkg::TIME_W-1:0]  m_delay_next;
    logic                        m_full_next;
    logic                        m_last_next;

    // RAM
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [otq_pkg::ENTRY_W-1:0]   ram_wdata;
    logic [otq_pkg::ENTRY_W-1:0]   ram_rdata;
    logic [otq_pkg::TIME_W-1:0]    rd_exp;
    logic [otq_pkg::INT_W-1:0]     rd_int;
    logic [otq_pkg::ID_W-1:0]      rd_id;
    logic                          cand;

    logic [otq_pkg::TIME_W:0]      reload_sum;
    logic [otq_pkg::TIME_W-1:0]    reload_exp;
    logic [otq_pkg::TIME_W-1:0]    deadline;
    logic [otq_pkg::TIME_W-1:0]    ahead;
    logic [otq_pkg::TIME_W-1:0]    clamped;
    logic                          rearm_calc;

    otq_ram #(
        .WIDTH (otq_pkg::ENTRY_W),
        .DEPTH (TIMER_SLOTS)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    assign rd_exp = ram_rdata[otq_pkg::TIME_W-1:0];
    assign rd_int = ram_rdata[otq_pkg::TIME_W +: otq_pkg::INT_W];
    assign rd_id  = ram_rdata[otq_pkg::TIME_W + otq_pkg::INT_W +: otq_pkg::ID_W];

    // saturating reload time
    assign reload_sum = {1'b0, now_reg} + {{(otq_pkg::TIME_W + 1 - otq_pkg::INT_W){1'b0}},
                                           best_int_reg};
    assign reload_exp = reload_sum[otq_pkg::TIME_W] ? '1 : reload_sum[otq_pkg::TIME_W-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = free_idx_reg;
        ram_wdata = {id_in_reg, int_in_reg, exp_in_reg};
        if (cmd.add_write) begin
            ram_we = 1'b1;
        end else if (cmd.fire_update && best_int_reg != '0) begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_reg;
            ram_wdata = {best_id_reg, best_int_reg, reload_exp};
        end
    end

    // scan comparator
    always_comb begin
        if (mode_reg == otq_pkg::SCAN_PICK) begin
            cand = valid_reg[rd_idx_reg] && !picked_reg[rd_idx_reg] && rd_exp <= now_reg &&
                   (!found_reg || rd_exp < best_exp_reg);
        end else begin
            cand = valid_reg[rd_idx_reg] && (!found_reg || rd_exp < best_exp_reg);
        end
    end

    // delay unit
    always_comb begin
        if (req_reg == otq_pkg::REQ_ADD) begin
            deadline   = exp_in_reg;
            rearm_calc = !found_reg || exp_in_reg < best_exp_reg;
        end else begin
            deadline   = best_exp_reg;
            rearm_calc = found_reg;
        end
        ahead   = (deadline > now_reg) ? deadline - now_reg : '0;
        clamped = (ahead < {{(otq_pkg::TIME_W - otq_pkg::MIN_W){1'b0}}, min_delay_reg}) ?
                  {{(otq_pkg::TIME_W - otq_pkg::MIN_W){1'b0}}, min_delay_reg} : ahead;
    end

    // next result beat
    always_comb begin
        m_id_next      = '0;
        m_fired_next   = 1'b0;
        m_changed_next = 1'b0;
        m_rearm_next   = 1'b0;
        m_delay_next   = '0;
        m_full_next    = 1'b0;
        m_last_next    = 1'b1;
        unique case (cmd.out_kind)
            otq_pkg::OUT_ADD: begin
                m_changed_next = changed_reg;
                m_rearm_next   = rearm_reg;
                m_delay_next   = delay_reg;
            end
            otq_pkg::OUT_FULL: begin
                m_full_next = 1'b1;
            end
            otq_pkg::OUT_FIRE_MID: begin
                m_id_next    = pend_id_reg;
                m_fired_next = 1'b1;
                m_last_next  = 1'b0;
            end
            otq_pkg::OUT_FIRE_LAST: begin
                m_id_next    = pend_id_reg;
                m_fired_next = 1'b1;
                m_rearm_next = rearm_reg;
                m_delay_next = delay_reg;
            end
            otq_pkg::OUT_TICK_NONE: begin
                m_rearm_next = rearm_reg;
                m_delay_next = delay_reg;
            end
            default: begin
                m_last_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_delay_reg <= otq_pkg::MIN_DELAY_RESET;
            valid_reg     <= '0;
            picked_reg    <= '0;
            run_reg       <= 1'b0;
            rd_vld_reg    <= 1'b0;
            done_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            fire_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                min_delay_reg <= cfg_wr_data;
            end
            // scan sequencing
            done_reg   <= rd_vld_reg && rd_idx_reg == LAST_IDX;
            rd_vld_reg <= run_reg;
            if (cmd.scan_start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                if (cnt_reg == LAST_IDX) begin
                    run_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            // slot flags and tick bookkeeping
            if (cmd.clear_pick) begin
                picked_reg   <= '0;
                pend_reg     <= 1'b0;
                fire_cnt_reg <= '0;
            end
            if (cmd.add_write) begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.fire_update) begin
                picked_reg[best_idx_reg] <= 1'b1;
                if (best_int_reg == '0) begin
                    valid_reg[best_idx_reg] <= 1'b0;
                end
                pend_reg     <= 1'b1;
                fire_cnt_reg <= fire_cnt_reg + 1'b1;
            end
            // result register
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg    <= s_req_type;
            now_reg    <= s_current_time;
            exp_in_reg <= s_expiry_time;
            int_in_reg <= s_repeat_interval;
            id_in_reg  <= s_new_timer_id;
        end
        rd_idx_reg <= cnt_reg;
        if (cmd.scan_start) begin
            mode_reg       <= cmd.scan_mode;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (rd_vld_reg) begin
            if (cand) begin
                found_reg    <= 1'b1;
                best_idx_reg <= rd_idx_reg;
                best_exp_reg <= rd_exp;
                best_int_reg <= rd_int;
                best_id_reg  <= rd_id;
            end
            if (!valid_reg[rd_idx_reg] && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg;
            end
        end
        if (cmd.fire_update) begin
            pend_id_reg <= best_id_reg;
        end
        if (cmd.calc) begin
            changed_reg <= rearm_calc;
            rearm_reg   <= rearm_calc;
            delay_reg   <= rearm_calc ? clamped : '0;
        end
        if (cmd.out_load) begin
            m_id_reg      <= m_id_next;
            m_fired_reg   <= m_fired_next;
            m_changed_reg <= m_changed_next;
            m_rearm_reg   <= m_rearm_next;
            m_delay_reg   <= m_delay_next;
            m_full_reg    <= m_full_next;
            m_last_reg    <= m_last_next;
        end
    end

    assign sts.scan_done  = done_reg;
    assign sts.found      = found_reg;
    assign sts.free_found = free_found_reg;
    assign sts.pend       = pend_reg;
    assign sts.fire_last  = fire_cnt_reg == otq_pkg::FIRE_CNT_W'(otq_pkg::MAX_RESULTS - 1);
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid            = m_valid_reg;
    assign m_fired_timer_id   = m_id_reg;
    assign m_fired            = m_fired_reg;
    assign m_earliest_changed = m_changed_reg;
    assign m_rearm            = m_rearm_reg;
    assign m_rearm_delay      = m_delay_reg;
    assign m_table_full       = m_full_reg;
    assign m_last             = m_last_reg;

endmodule
